// ===== rtl/core/utf8_lossy_sanitizer_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 lossy sanitizer assertion macros
// Shared concurrent assertion forms for the sanitizer modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_LOSSY_SANITIZER_ASSERT_SVH
`define UTF8_LOSSY_SANITIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ULS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utf8_lossy_sanitizer: assertion failed");

// next-cycle implication, disabled during reset
`define ULS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utf8_lossy_sanitizer: assertion failed");

`endif

// ===== rtl/core/uls_pkg.sv =====
// ----------------------------------------------------------------------------
// uls_pkg
// Types and byte constants shared by the UTF-8 lossy sanitizer modules.
// ----------------------------------------------------------------------------
package uls_pkg;

    localparam logic [7:0] REPL_B0   = 8'hEF;
    localparam logic [7:0] REPL_B1   = 8'hBF;
    localparam logic [7:0] REPL_B2   = 8'hBD;

    localparam logic [7:0] LEAD2_MIN = 8'hC2;
    localparam logic [7:0] LEAD2_MAX = 8'hDF;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD3_MAX = 8'hEF;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_ED   = 8'hED;

    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] CONT_MAX  = 8'hBF;
    localparam logic [7:0] E0_MIN    = 8'hA0;
    localparam logic [7:0] ED_MAX    = 8'h9F;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8F;

    // one command per input byte that produces output
    typedef struct packed {
        logic            pre_rep;
        logic [2:0]      lit_count;
        logic [3:0][7:0] lit;
        logic            mid_rep;
        logic            post_rep;
        logic            eoi;
    } cmd_t;

endpackage

// ===== rtl/core/uls_front.sv =====
// ----------------------------------------------------------------------------
// uls_front
// Classifies each input byte against the pending prefix and issues one
// output command per byte that produces output.
// ----------------------------------------------------------------------------
`include "utf8_lossy_sanitizer_assert.svh"

module uls_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          end_of_input,
    output logic          push,
    output uls_pkg::cmd_t cmd
);

    logic [7:0] pfx_reg [0:2];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] len_reg, len_next;

    logic       pending;
    logic       do_lead;
    logic       wr_lead;
    logic       wr_ext;
    logic [2:0] lead_len;
    logic [7:0] lo, hi;
    uls_pkg::cmd_t c;

    always_comb begin
        pending = (cnt_reg != 2'd0) && (len_reg >= 3'd2) && (len_reg <= 3'd4)
                  && ({1'b0, cnt_reg} < len_reg);

        if (in_byte inside {[uls_pkg::LEAD2_MIN:uls_pkg::LEAD2_MAX]}) begin
            lead_len = 3'd2;
        end else if (in_byte inside {[uls_pkg::LEAD3_MIN:uls_pkg::LEAD3_MAX]}) begin
            lead_len = 3'd3;
        end else if (in_byte inside {[uls_pkg::LEAD4_MIN:uls_pkg::LEAD4_MAX]}) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end

        lo = uls_pkg::CONT_MIN;
        hi = uls_pkg::CONT_MAX;
        if (cnt_reg == 2'd1) begin
            case (pfx_reg[0])
                uls_pkg::LEAD3_MIN: lo = uls_pkg::E0_MIN;
                uls_pkg::LEAD_ED:   hi = uls_pkg::ED_MAX;
                uls_pkg::LEAD4_MIN: lo = uls_pkg::F0_MIN;
                uls_pkg::LEAD4_MAX: hi = uls_pkg::F4_MAX;
                default: ;
            endcase
        end

        c        = '0;
        cnt_next = cnt_reg;
        len_next = len_reg;
        do_lead  = 1'b0;
        wr_lead  = 1'b0;
        wr_ext   = 1'b0;

        if (pending) begin
            if (in_byte >= lo && in_byte <= hi) begin
                if ({1'b0, cnt_reg} + 3'd1 == len_reg) begin
                    c.lit_count = len_reg;
                    for (int i = 0; i < 3; i++) begin
                        c.lit[i] = (2'(i) < cnt_reg) ? pfx_reg[i] : in_byte;
                    end
                    c.lit[3] = in_byte;
                    cnt_next = 2'd0;
                    len_next = 3'd0;
                end else begin
                    wr_ext   = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                end
            end else begin
                c.pre_rep = 1'b1;
                cnt_next  = 2'd0;
                len_next  = 3'd0;
                do_lead   = 1'b1;
            end
        end else begin
            cnt_next = 2'd0;
            len_next = 3'd0;
            do_lead  = 1'b1;
        end

        if (do_lead) begin
            if (!in_byte[7]) begin
                c.lit_count = 3'd1;
                c.lit[0]    = in_byte;
            end else if (lead_len != 3'd0) begin
                wr_lead  = 1'b1;
                cnt_next = 2'd1;
                len_next = lead_len;
            end else begin
                c.mid_rep = 1'b1;
            end
        end

        if (end_of_input && cnt_next != 2'd0) begin
            c.post_rep = 1'b1;
            cnt_next   = 2'd0;
            len_next   = 3'd0;
        end

        c.eoi = end_of_input;
    end

    assign cmd  = c;
    assign push = accept && (c.pre_rep || c.mid_rep || c.post_rep || c.lit_count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && wr_lead) begin
            pfx_reg[0] <= in_byte;
        end else if (accept && wr_ext) begin
            pfx_reg[cnt_reg] <= in_byte;
        end
    end

    `ULS_ASSERT_NOW(a_prefix_shape, aclk, aresetn, cnt_reg != 2'd0,
        len_reg >= 3'd2 && len_reg <= 3'd4 && 3'(cnt_reg) < len_reg)
    `ULS_ASSERT_NEXT(a_eoi_flush, aclk, aresetn, accept && end_of_input,
        cnt_reg == 2'd0)

endmodule

// ===== rtl/core/uls_queue.sv =====
// ----------------------------------------------------------------------------
// uls_queue
// Small command FIFO between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module uls_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  uls_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          head_valid,
    output uls_pkg::cmd_t head_cmd,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uls_pkg::cmd_t mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/uls_back.sv =====
// ----------------------------------------------------------------------------
// uls_back
// Expands queued commands into output beats, one byte per cycle when not
// stalled by m_ready, into a registered output stage.
// ----------------------------------------------------------------------------
`include "utf8_lossy_sanitizer_assert.svh"

module uls_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  uls_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_is_substitute,
    output logic          m_run_last,
    output logic          m_stream_done
);

    localparam logic [1:0] SEG_PRE  = 2'd0;
    localparam logic [1:0] SEG_LIT  = 2'd1;
    localparam logic [1:0] SEG_MID  = 2'd2;
    localparam logic [1:0] SEG_POST = 2'd3;

    function automatic logic seg_present(uls_pkg::cmd_t c, logic [1:0] s);
        logic r;
        case (s)
            SEG_PRE:  r = c.pre_rep;
            SEG_LIT:  r = (c.lit_count != 3'd0);
            SEG_MID:  r = c.mid_rep;
            SEG_POST: r = c.post_rep;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    // lowest present segment at or after from; 4 when none
    function automatic logic [2:0] first_seg(uls_pkg::cmd_t c, logic [2:0] from);
        logic [2:0] r;
        r = 3'd4;
        for (int s = 3; s >= 0; s--) begin
            if (3'(s) >= from && seg_present(c, 2'(s))) begin
                r = 3'(s);
            end
        end
        return r;
    endfunction

    logic [1:0] seg_reg, idx_reg;
    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_sub_reg, m_last_reg, m_done_reg;

    logic [2:0] cur_full, nxt_seg;
    logic [1:0] cur;
    logic       is_rep, seg_end, entry_end, emit;
    logic [7:0] cur_byte;

    always_comb begin
        cur_full = first_seg(head_cmd, {1'b0, seg_reg});
        cur      = cur_full[1:0];
        is_rep   = (cur != SEG_LIT);
        if (is_rep) begin
            case (idx_reg)
                2'd0:    cur_byte = uls_pkg::REPL_B0;
                2'd1:    cur_byte = uls_pkg::REPL_B1;
                default: cur_byte = uls_pkg::REPL_B2;
            endcase
            seg_end = (idx_reg == 2'd2);
        end else begin
            cur_byte = head_cmd.lit[idx_reg];
            seg_end  = ({1'b0, idx_reg} + 3'd1 == head_cmd.lit_count);
        end
        nxt_seg   = first_seg(head_cmd, {1'b0, cur} + 3'd1);
        entry_end = seg_end && nxt_seg[2];
        emit      = head_valid && (!m_valid_reg || m_ready);
    end

    assign pop = emit && entry_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg     <= SEG_PRE;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
                if (entry_end) begin
                    seg_reg <= SEG_PRE;
                    idx_reg <= 2'd0;
                end else if (seg_end) begin
                    seg_reg <= nxt_seg[1:0];
                    idx_reg <= 2'd0;
                end else begin
                    seg_reg <= cur;
                    idx_reg <= idx_reg + 2'd1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg <= cur_byte;
            m_sub_reg  <= is_rep;
            m_last_reg <= entry_end;
            m_done_reg <= entry_end && head_cmd.eoi;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_is_substitute = m_sub_reg;
    assign m_run_last      = m_last_reg;
    assign m_stream_done   = m_done_reg;

    `ULS_ASSERT_NOW(a_done_is_last, aclk, aresetn, m_valid_reg && m_done_reg,
        m_last_reg)
    `ULS_ASSERT_NOW(a_sub_bytes, aclk, aresetn, m_valid_reg && m_sub_reg,
        m_byte_reg == uls_pkg::REPL_B0 || m_byte_reg == uls_pkg::REPL_B1 ||
        m_byte_reg == uls_pkg::REPL_B2)

endmodule

// ===== rtl/core/utf8_lossy_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_lossy_sanitizer
// Passes valid UTF-8 through and replaces each ill-formed maximal subpart
// with EF BF BD.
// ----------------------------------------------------------------------------
// Accepted beats are queued as commands before the registered output stage.
// Throughput: one input beat per cycle while the command queue has room;
// output runs one byte per cycle when m_ready allows, up to 6 bytes for
// one input byte. The output sequencer's byte rate sets the sustained rate.
// Reset (aresetn low, synchronous): pending prefix, queue and output cleared.
module utf8_lossy_sanitizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_substitute,
    output logic       m_run_last,
    output logic       m_stream_done
);

    logic          accept;
    logic          push, pop, full, head_valid;
    uls_pkg::cmd_t push_cmd, head_cmd;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    uls_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .push         (push),
        .cmd          (push_cmd)
    );

    uls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (full)
    );

    uls_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_substitute (m_is_substitute),
        .m_run_last      (m_run_last),
        .m_stream_done   (m_stream_done)
    );

endmodule
